>>> design/skst_pkg.sv
// ----------------------------------------------------------------------------
// skst_pkg: shared types and constants for the sorted key set table.
// Holds the table capacity, the transaction structs, the request and status
// codes, the cell command and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package skst_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int POS_W    = 4;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_DUP      = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CMP  = 2'd1,
    ST_UPD  = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] position;
    logic [4:0]       entry_count;
  } out_item_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cell_op_t                op;
    logic [IDX_W-1:0]        pos;
    logic signed [KEY_W-1:0] key;
  } cell_cmd_t;

  // Compare result that each cell reports back.
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

`default_nettype wire

>>> design/skst_cell.sv
// ----------------------------------------------------------------------------
// skst_cell: one slot of the sorted key chain.
// Holds one key, compares it with the probe key every cycle and shifts
// toward either neighbor when an insert or delete is broadcast.
// ----------------------------------------------------------------------------
`default_nettype none

module skst_cell (
  input  wire logic                              clk,
  input  wire logic [skst_pkg::IDX_W-1:0]        idx,
  input  wire logic                              occ,
  input  wire logic signed [skst_pkg::KEY_W-1:0] probe_key,
  input  wire skst_pkg::cell_cmd_t               cmd,
  input  wire logic signed [skst_pkg::KEY_W-1:0] left_key,
  input  wire logic signed [skst_pkg::KEY_W-1:0] right_key,
  output logic signed [skst_pkg::KEY_W-1:0]      key_out,
  output skst_pkg::cell_flags_t                  flags
);

  logic signed [skst_pkg::KEY_W-1:0] key_r, key_nxt;
  skst_pkg::cell_flags_t             flags_r, flags_nxt;

  always_comb begin
    key_nxt = key_r;
    case (cmd.op)
      skst_pkg::CELL_INS: begin
        if (idx == cmd.pos) begin
          key_nxt = cmd.key;
        end else if (idx > cmd.pos) begin
          key_nxt = left_key;
        end
      end
      skst_pkg::CELL_DEL: begin
        if (idx >= cmd.pos) begin
          key_nxt = right_key;
        end
      end
      default: key_nxt = key_r;
    endcase
  end

  // Empty slots never report a match, so unwritten contents are never used.
  always_comb begin
    flags_nxt.lt = occ && (key_r < probe_key);
    flags_nxt.eq = occ && (key_r == probe_key);
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    flags_r <= flags_nxt;
  end

  assign key_out = key_r;
  assign flags   = flags_r;

endmodule

`default_nettype wire

>>> design/sorted_key_set_table.sv
// ----------------------------------------------------------------------------
// sorted_key_set_table: bounded set of unique signed keys in ascending order.
// A chain of key cells compares every slot against a request key in
// parallel; a small controller turns the compare flags into a sorted
// position and broadcasts a shift-insert or shift-delete to the chain.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                        | Payload
//   --------+------------------------------+-----------------------------------
//   request | in_valid, in_stall, in_data  | req_type, key
//   result  | out_valid, out_stall,        | status, position, entry_count
//           | out_data                     |
//
// Each request passes the accepting edge, a compare state in which all
// cells compare their key with the request key and register the result, and
// an update state in which the position is decoded and the chain shifts.
// The result register lets the next request be accepted while a finished
// result still waits; a stalled result holds the update cycle until it drains.
// Reset (rst_n low, synchronous) empties the table and clears the control
// state; key slots are not cleared since only slots below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_set_table (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire skst_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output skst_pkg::out_item_t      out_data
);

  localparam int N = skst_pkg::CAPACITY;

  skst_pkg::ctrl_state_t state_r, state_nxt;

  // The request under work; its key is the probe for every cell.
  logic [1:0]                        req_r, req_nxt;
  logic signed [skst_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [skst_pkg::CNT_W-1:0]        count_r, count_nxt;

  logic                out_valid_r, out_valid_nxt;
  skst_pkg::out_item_t out_data_r, out_data_nxt;

  skst_pkg::cell_cmd_t   cmd;
  skst_pkg::cell_flags_t flags [N];
  logic signed [skst_pkg::KEY_W-1:0] cell_key [N];
  logic [N-1:0] occ;
  logic [N-1:0] lt_vec;
  logic [N-1:0] eq_vec;

  logic [skst_pkg::CNT_W-1:0] lb;
  logic                       found;
  logic                       fire;
  logic                       in_accept;

  // The chain of cells. Each cell sees both neighbors' keys for shifting.
  for (genvar g = 0; g < N; g++) begin : g_cell
    logic signed [skst_pkg::KEY_W-1:0] left_k;
    logic signed [skst_pkg::KEY_W-1:0] right_k;

    if (g == 0) begin : g_first
      assign left_k = '0;
    end else begin : g_mid_l
      assign left_k = cell_key[g-1];
    end
    if (g == N - 1) begin : g_last
      assign right_k = '0;
    end else begin : g_mid_r
      assign right_k = cell_key[g+1];
    end

    assign occ[g] = (skst_pkg::CNT_W'(g) < count_r);

    skst_cell u_cell (
      .clk       (clk),
      .idx       (skst_pkg::IDX_W'(g)),
      .occ       (occ[g]),
      .probe_key (key_r),
      .cmd       (cmd),
      .left_key  (left_k),
      .right_key (right_k),
      .key_out   (cell_key[g]),
      .flags     (flags[g])
    );

    assign lt_vec[g] = flags[g].lt;
    assign eq_vec[g] = flags[g].eq;
  end

  // Held keys are sorted, so the less-than flags form a thermometer code:
  // the first clear flag is the key's sorted position. Since keys are unique,
  // at most one slot can match and it sits exactly at that position.
  always_comb begin
    lb = skst_pkg::CNT_W'(N);
    for (int i = N - 1; i >= 0; i--) begin
      if (!lt_vec[i]) begin
        lb = skst_pkg::CNT_W'(i);
      end
    end
    found = |eq_vec;
  end

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != skst_pkg::ST_IDLE);
  // The update commits only when the result register can take its result.
  assign fire      = (state_r == skst_pkg::ST_UPD) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    key_nxt       = key_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    cmd.op        = skst_pkg::CELL_HOLD;
    cmd.pos       = lb[skst_pkg::IDX_W-1:0];
    cmd.key       = key_r;

    case (state_r)
      skst_pkg::ST_IDLE: begin
        if (in_accept) begin
          req_nxt   = in_data.req_type;
          key_nxt   = in_data.key;
          state_nxt = skst_pkg::ST_CMP;
        end
      end
      skst_pkg::ST_CMP: begin
        state_nxt = skst_pkg::ST_UPD;
      end
      skst_pkg::ST_UPD: begin
        if (fire) begin
          out_data_nxt.status   = skst_pkg::STAT_DONE;
          out_data_nxt.position = '0;
          case (skst_pkg::req_type_t'(req_r))
            skst_pkg::REQ_INSERT: begin
              if (found) begin
                out_data_nxt.status   = skst_pkg::STAT_DUP;
                out_data_nxt.position = lb[skst_pkg::POS_W-1:0];
              end else if (count_r >= skst_pkg::CNT_W'(N)) begin
                out_data_nxt.status = skst_pkg::STAT_FULL;
              end else begin
                cmd.op                = skst_pkg::CELL_INS;
                count_nxt             = count_r + 1'b1;
                out_data_nxt.position = lb[skst_pkg::POS_W-1:0];
              end
            end
            skst_pkg::REQ_DELETE: begin
              if (found) begin
                cmd.op                = skst_pkg::CELL_DEL;
                count_nxt             = count_r - 1'b1;
                out_data_nxt.position = lb[skst_pkg::POS_W-1:0];
              end else begin
                out_data_nxt.status = skst_pkg::STAT_NOTFOUND;
              end
            end
            skst_pkg::REQ_SEARCH: begin
              if (found) begin
                out_data_nxt.position = lb[skst_pkg::POS_W-1:0];
              end else begin
                out_data_nxt.status = skst_pkg::STAT_NOTFOUND;
              end
            end
            default: begin
              count_nxt = '0;
            end
          endcase
          out_data_nxt.entry_count = 5'(count_nxt);
          out_valid_nxt            = 1'b1;
          state_nxt                = skst_pkg::ST_IDLE;
        end
      end
      default: state_nxt = skst_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skst_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The held count can never pass the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= skst_pkg::CNT_W'(N))
    else $error("held count above capacity");

  // Unique keys: at most one slot may match the probe.
  a_eq_unique: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == skst_pkg::ST_UPD |-> $onehot0(eq_vec))
    else $error("more than one slot matched the probe key");

  // A full report always comes with a full table.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == skst_pkg::STAT_FULL |->
      out_data_r.entry_count == 5'(N))
    else $error("full status with a table that is not full");

  // An accepted request moves straight to the compare cycle.
  a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == skst_pkg::ST_CMP)
    else $error("accepted request did not enter compare");

  // A fresh result that was not a change to the table keeps the count.
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cmd.op == skst_pkg::CELL_HOLD && req_r != skst_pkg::REQ_CLEAR |=>
      $stable(count_r))
    else $error("count changed without an insert, delete or clear");

endmodule

`default_nettype wire

>>> bench/tb_sorted_key_set_table.sv
// ----------------------------------------------------------------------------
// tb_sorted_key_set_table: self-checking bench for the sorted key set table.
// Drives insert, delete, search and clear transactions with random gaps and
// result back-pressure, tracks the expected table contents in a scoreboard,
// and compares every result field by field in order.
// ----------------------------------------------------------------------------
module tb_sorted_key_set_table;

  // Tracks the key set the block should hold and the results it owes.
  class key_set_scoreboard;
    logic signed [skst_pkg::KEY_W-1:0] held_keys [skst_pkg::CAPACITY];
    int                                held_count;
    skst_pkg::out_item_t               owed_results [$];
    int                                failures;

    function new();
      held_count = 0;
      failures   = 0;
    endfunction

    // Applies one request to the tracked table and returns its result.
    function skst_pkg::out_item_t apply_request(skst_pkg::in_item_t req);
      skst_pkg::out_item_t               res;
      logic signed [skst_pkg::KEY_W-1:0] k;
      int                                lb;
      bit                                hit;
      res = '0;
      k   = req.key;
      if (req.req_type == skst_pkg::REQ_CLEAR) begin
        held_count = 0;
      end else begin
        // The sorted position is the number of held keys below the request key.
        lb = 0;
        while (lb < held_count && held_keys[lb] < k) lb++;
        hit = (lb < held_count) && (held_keys[lb] == k);
        case (req.req_type)
          skst_pkg::REQ_INSERT: begin
            // A duplicate wins over a full table.
            if (hit) begin
              res.status   = skst_pkg::STAT_DUP;
              res.position = lb[skst_pkg::POS_W-1:0];
            end else if (held_count >= skst_pkg::CAPACITY) begin
              res.status = skst_pkg::STAT_FULL;
            end else begin
              for (int i = held_count; i > lb; i--) held_keys[i] = held_keys[i-1];
              held_keys[lb] = k;
              held_count++;
              res.position = lb[skst_pkg::POS_W-1:0];
            end
          end
          skst_pkg::REQ_DELETE: begin
            if (hit) begin
              for (int i = lb; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
              held_count--;
              res.position = lb[skst_pkg::POS_W-1:0];
            end else begin
              res.status = skst_pkg::STAT_NOTFOUND;
            end
          end
          default: begin
            if (hit) res.position = lb[skst_pkg::POS_W-1:0];
            else     res.status   = skst_pkg::STAT_NOTFOUND;
          end
        endcase
      end
      res.entry_count = held_count[4:0];
      return res;
    endfunction

    function void note_request(skst_pkg::in_item_t req);
      owed_results.push_back(apply_request(req));
    endfunction

    function void check_result(skst_pkg::out_item_t got);
      skst_pkg::out_item_t exp;
      if (owed_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: status %0d position %0d count %0d",
                   got.status, got.position, got.entry_count);
      end else begin
        exp = owed_results.pop_front();
        if (got.status !== exp.status || got.position !== exp.position ||
            got.entry_count !== exp.entry_count) begin
          failures++;
          if (failures <= 10)
            $display({"result mismatch: expected status %0d position %0d count %0d,",
                      " got status %0d position %0d count %0d"},
                     exp.status, exp.position, exp.entry_count,
                     got.status, got.position, got.entry_count);
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  skst_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  skst_pkg::out_item_t out_data;

  key_set_scoreboard sb;

  // When set, neither side inserts gaps or stalls, so transactions go back
  // to back through the compare and update cycles.
  bit burst_mode;

  // Pool of keys for the random part; kept a bit larger than the capacity so
  // that the table fills up, while hits and duplicates stay frequent.
  localparam int POOL_SIZE = 24;
  logic [skst_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

  sorted_key_set_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // The run is far shorter than this even with every gap and stall at its
  // longest; reaching it means the block hung.
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Keys for random transactions: pool keys most of the time, otherwise
  // fully random values or values next to the signed extremes and zero.
  function automatic logic [skst_pkg::KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 85) return $urandom;
    case ($urandom_range(0, 2))
      0:       return 32'h8000_0000 + 32'($urandom_range(0, 3));
      1:       return 32'h7fff_ffff - 32'($urandom_range(0, 3));
      default: return 32'($urandom_range(0, 6)) - 32'd3;
    endcase
  endfunction

  // Offers one request and holds it until the block accepts it. The valid
  // is only lowered when a gap follows, so back-to-back transactions keep it
  // high across the accepting edge.
  task automatic send_request(skst_pkg::req_type_t rt, logic [skst_pkg::KEY_W-1:0] key);
    int                 gap;
    skst_pkg::in_item_t item;
    gap           = pick_gap();
    item.req_type = rt;
    item.key      = key;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Result side back-pressure: stall runs of random length separated by
  // free runs of random length. Nothing is driven here until reset
  // has been released.
  initial begin
    int len;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      len = pick_gap();
      if (len > 0) begin
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Monitor. Values read here are the ones present before the edge, so a
  // transaction is taken exactly when valid was high and stall low. The
  // result is checked before the request of the same edge is noted, since a
  // request can never produce its result at its own accepting edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_request(in_data);
    end
  end

  initial begin
    int sent;
    int seg_len;
    int clear_pct;
    int ins_pct;
    int del_pct;
    int r;
    sb         = new();
    burst_mode = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: requests on an empty table, the signed extremes and
    // keys around zero, a duplicate insert, hits and misses for search and
    // delete, removal of the first and last entries, and clears with
    // arbitrary key fields.
    send_request(skst_pkg::REQ_SEARCH, 32'h0000_0000);
    send_request(skst_pkg::REQ_DELETE, 32'h0000_0005);
    send_request(skst_pkg::REQ_CLEAR,  32'hffff_ffff);
    send_request(skst_pkg::REQ_INSERT, 32'h8000_0000);
    send_request(skst_pkg::REQ_INSERT, 32'h7fff_ffff);
    send_request(skst_pkg::REQ_INSERT, 32'h0000_0000);
    send_request(skst_pkg::REQ_INSERT, 32'hffff_ffff);
    send_request(skst_pkg::REQ_INSERT, 32'h0000_0001);
    send_request(skst_pkg::REQ_INSERT, 32'h0000_0000);
    send_request(skst_pkg::REQ_SEARCH, 32'h7fff_ffff);
    send_request(skst_pkg::REQ_SEARCH, 32'h0000_0002);
    send_request(skst_pkg::REQ_DELETE, 32'h0000_0000);
    send_request(skst_pkg::REQ_DELETE, 32'h0000_0000);
    send_request(skst_pkg::REQ_SEARCH, 32'h8000_0000);
    send_request(skst_pkg::REQ_DELETE, 32'h8000_0000);
    send_request(skst_pkg::REQ_DELETE, 32'h7fff_ffff);
    send_request(skst_pkg::REQ_CLEAR,  32'h1234_5678);
    send_request(skst_pkg::REQ_SEARCH, 32'h0000_0001);

    // Random part in segments. Each segment draws a fresh key pool and its
    // own request mix; insert-heavy segments fill the table so that full and
    // duplicate-when-full cases come up, delete-heavy ones drain it again.
    sent = 0;
    while (sent < 1000) begin
      seg_len    = $urandom_range(50, 150);
      burst_mode = ($urandom_range(0, 3) == 0);
      clear_pct  = $urandom_range(0, 4);
      ins_pct    = $urandom_range(30, 70);
      del_pct    = $urandom_range(10, 35);
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;
      for (int n = 0; n < seg_len; n++) begin
        r = $urandom_range(0, 99);
        if (r < clear_pct)
          send_request(skst_pkg::REQ_CLEAR, $urandom);
        else if (r < clear_pct + ins_pct)
          send_request(skst_pkg::REQ_INSERT, pick_key());
        else if (r < clear_pct + ins_pct + del_pct)
          send_request(skst_pkg::REQ_DELETE, pick_key());
        else
          send_request(skst_pkg::REQ_SEARCH, pick_key());
        sent++;
      end
    end
    burst_mode = 1'b0;
    in_valid  <= 1'b0;

    // Drain: wait for every owed result, then keep the clock running so that
    // a stray extra result would still be caught.
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.failures == 0 && sb.owed_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
